/* hw/rtl/ils_pkg.sv */
// Shared types and codes for the indexed list store.
// Used by ils_cell, ils_ctrl and indexed_list_store; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

   // Operation codes carried on req_operation.
   localparam logic [2:0] OP_PUSH   = 3'd0;
   localparam logic [2:0] OP_POP    = 3'd1;
   localparam logic [2:0] OP_GET    = 3'd2;
   localparam logic [2:0] OP_SET    = 3'd3;
   localparam logic [2:0] OP_INSERT = 3'd4;
   localparam logic [2:0] OP_REMOVE = 3'd5;
   localparam logic [2:0] OP_CLEAR  = 3'd6;

   // Status codes carried on rsp_status.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Command that every cell of the row sees in the same cycle.
   typedef logic [1:0] cell_mode_type;
   localparam cell_mode_type MODE_HOLD   = 2'd0;
   localparam cell_mode_type MODE_WRITE  = 2'd1;
   localparam cell_mode_type MODE_INSERT = 2'd2;
   localparam cell_mode_type MODE_REMOVE = 2'd3;

   // Response flags produced by the decoder.
   typedef struct packed {
      logic       has_item;
      logic [1:0] status;
   } rsp_info_type;

endpackage

`default_nettype wire

/* hw/rtl/ils_cell.sv */
// One storage cell of the list row: holds a single entry and trades it with its neighbors.
// Depends on ils_pkg for the cell command codes.
`timescale 1ns / 1ps
`default_nettype none

module ils_cell #(
   parameter int DW         = 32,
   parameter int IW         = 7,
   parameter int CELL_INDEX = 0
) (
   input  wire                    clock,
   input  wire ils_pkg::cell_mode_type mode,
   input  wire [IW-1:0]           cmd_index,
   input  wire [DW-1:0]           wr_value,
   input  wire [DW-1:0]           prev_q,
   input  wire [DW-1:0]           next_q,
   input  wire [IW-1:0]           rd_index,
   output logic [DW-1:0]          q,
   output logic [DW-1:0]          rd_out
);
   import ils_pkg::*;

   localparam logic [IW-1:0] MY_INDEX = IW'(CELL_INDEX);

   logic [DW-1:0] entry_ff;
   logic [DW-1:0] entry_in;
   logic          hit;
   logic          above;

   assign hit   = (cmd_index == MY_INDEX);
   assign above = (MY_INDEX > cmd_index);

   always_comb begin
      entry_in = entry_ff;
      unique case (mode)
         MODE_WRITE: begin
            if (hit) entry_in = wr_value;
         end
         MODE_INSERT: begin
            // Cells above the insertion point take their lower neighbor's entry.
            if (hit) entry_in = wr_value;
            else if (above) entry_in = prev_q;
         end
         MODE_REMOVE: begin
            if (hit || above) entry_in = next_q;
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q      = entry_ff;
   assign rd_out = (rd_index == MY_INDEX) ? entry_ff : '0;

endmodule

`default_nettype wire

/* hw/rtl/ils_ctrl.sv */
// Request decoder: turns an operation, position and count into a cell command and response flags.
// Depends on ils_pkg for operation, status and command codes.
`timescale 1ns / 1ps
`default_nettype none

module ils_ctrl #(
   parameter int CAPACITY = 16,
   parameter int CW       = 5,
   parameter int IW       = 7
) (
   input  wire                    start,
   input  wire [2:0]              operation,
   input  wire [7:0]              position,
   input  wire [CW-1:0]           count,
   output ils_pkg::cell_mode_type cell_mode,
   output logic [IW-1:0]          cell_index,
   output logic [IW-1:0]          rd_index,
   output logic [CW-1:0]          new_count,
   output ils_pkg::rsp_info_type  info
);
   import ils_pkg::*;

   logic          negative;
   logic [IW-1:0] idx;
   logic [IW-1:0] cnt;
   logic          in_range;
   logic          full;

   assign negative = position[7];
   assign idx      = IW'(position[6:0]);
   assign cnt      = IW'(count);
   assign in_range = !negative && (idx < cnt);
   assign full     = (count == CW'(CAPACITY));

   always_comb begin
      cell_mode     = MODE_HOLD;
      cell_index    = cnt;
      rd_index      = idx;
      new_count     = count;
      info.has_item = 1'b0;
      info.status   = ST_OK;
      unique case (operation) inside
         OP_PUSH: begin
            if (full) begin
               info.status = ST_FULL;
            end else begin
               cell_mode = MODE_WRITE;
               new_count = count + 1'b1;
            end
         end
         OP_POP: begin
            if (count == '0) begin
               info.status = ST_RANGE;
            end else begin
               rd_index      = cnt - 1'b1;
               info.has_item = 1'b1;
               new_count     = count - 1'b1;
            end
         end
         OP_GET: begin
            if (!in_range) info.status = ST_RANGE;
            else info.has_item = 1'b1;
         end
         OP_SET, OP_INSERT: begin
            if (negative) begin
               info.status = ST_RANGE;
            end else if (!in_range) begin
               // Past the count both operations append at the tail.
               if (full) begin
                  info.status = ST_FULL;
               end else begin
                  cell_mode = MODE_WRITE;
                  new_count = count + 1'b1;
               end
            end else if (operation == OP_SET) begin
               cell_mode     = MODE_WRITE;
               cell_index    = idx;
               info.has_item = 1'b1;
            end else if (full) begin
               info.status = ST_FULL;
            end else begin
               cell_mode  = MODE_INSERT;
               cell_index = idx;
               new_count  = count + 1'b1;
            end
         end
         OP_REMOVE: begin
            if (!in_range) begin
               info.status = ST_RANGE;
            end else begin
               cell_mode     = MODE_REMOVE;
               cell_index    = idx;
               info.has_item = 1'b1;
               new_count     = count - 1'b1;
            end
         end
         OP_CLEAR: begin
            new_count = '0;
         end
         default: begin
            cell_mode = MODE_HOLD;
         end
      endcase
      if (!start) begin
         cell_mode = MODE_HOLD;
         new_count = count;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/indexed_list_store.sv */
// Top level of the indexed list store: a row of entry cells, the decoder and the response register.
// Depends on ils_pkg, ils_ctrl and ils_cell.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// A request is taken at each rising edge where start is high and busy is low.
// busy is held low, so one request can be issued in every cycle.
// req_operation selects push, pop, get, set, insert, remove or clear;
// req_position is the signed entry index and req_item_value the word to store.
// Each request yields exactly one response, shown for one cycle with rsp_valid
// high in the cycle after the request edge (throughput one request per cycle).
// Every cell of the row updates in the same edge, so an insert or remove shifts
// all later entries at once.
// rsp_item_out carries the popped, read, replaced or removed entry when
// rsp_has_item is high and is zero otherwise; rsp_status is ok, range or full;
// rsp_entry_count is the count after the request.
// Reset clears the entry count and the response strobe; stored entries are
// left as they are and are never read before they are written again.
// The receiver cannot stall: a response is simply gone after its one cycle.
module indexed_list_store #(
   parameter int CAPACITY  = 16,
   parameter int ITEM_BITS = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [2:0]  req_operation,
   input  wire  [7:0]  req_position,
   input  wire  [31:0] req_item_value,
   output logic        rsp_valid,
   output logic [31:0] rsp_item_out,
   output logic        rsp_has_item,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_entry_count
);
   import ils_pkg::*;

   localparam int DW = (ITEM_BITS < 32) ? ITEM_BITS : 32;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = (CW > 7) ? CW : 7;

   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;
   cell_mode_type  cell_mode;
   logic [IW-1:0]  cell_index;
   logic [IW-1:0]  rd_index;
   rsp_info_type   info;
   logic [DW-1:0]  wr_value;
   logic [DW-1:0]  cell_q   [CAPACITY];
   logic [DW-1:0]  cell_rd  [CAPACITY];
   logic [DW-1:0]  rd_data;
   logic           accept;

   logic           rsp_valid_ff;
   logic [31:0]    rsp_item_ff;
   rsp_info_type   rsp_info_ff;
   logic [4:0]     rsp_count_ff;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign wr_value = DW'(req_item_value);

   ils_ctrl #(
      .CAPACITY (CAPACITY),
      .CW       (CW),
      .IW       (IW)
   ) u_ctrl (
      .start      (accept),
      .operation  (req_operation),
      .position   (req_position),
      .count      (count_ff),
      .cell_mode  (cell_mode),
      .cell_index (cell_index),
      .rd_index   (rd_index),
      .new_count  (count_in),
      .info       (info)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DW-1:0] prev_q;
      logic [DW-1:0] next_q;
      if (i == 0) begin : g_first
         assign prev_q = '0;
      end else begin : g_prev
         assign prev_q = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_q = '0;
      end else begin : g_next
         assign next_q = cell_q[i+1];
      end
      ils_cell #(
         .DW         (DW),
         .IW         (IW),
         .CELL_INDEX (i)
      ) u_cell (
         .clock     (clock),
         .mode      (cell_mode),
         .cmd_index (cell_index),
         .wr_value  (wr_value),
         .prev_q    (prev_q),
         .next_q    (next_q),
         .rd_index  (rd_index),
         .q         (cell_q[i]),
         .rd_out    (cell_rd[i])
      );
   end

   // At most one cell matches the read index, so the row's outputs are ORed.
   always_comb begin
      rd_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_data = rd_data | cell_rd[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_item_ff  <= info.has_item ? 32'(rd_data) : 32'd0;
         rsp_info_ff  <= info;
         rsp_count_ff <= 5'(count_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item_out    = rsp_item_ff;
   assign rsp_has_item    = rsp_info_ff.has_item;
   assign rsp_status      = rsp_info_ff.status;
   assign rsp_entry_count = rsp_count_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept))
      else $error("response without a request");

   a_has_item_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_has_item) |-> (rsp_status == ST_OK))
      else $error("entry returned with a failing status");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation != OP_CLEAR) |=>
         (count_ff == $past(count_ff) || count_ff == $past(count_ff) + 1'b1
          || count_ff == $past(count_ff) - 1'b1))
      else $error("entry count moved by more than one");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for indexed_list_store: directed corner requests, then random
// request streams checked against a shadow copy of the list kept in a scoreboard class.
// Depends on ils_pkg and the indexed_list_store RTL.

module tb_top;
   import ils_pkg::*;

   localparam int CAPACITY = 16;
   localparam int RANDOM_REQUESTS = 1680;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 4;
   localparam int REPORT_LIMIT = 10;
   localparam logic [2:0] OP_UNUSED = 3'd7;

   typedef struct packed {
      logic [31:0] item;
      logic        has;
      logic [1:0]  status;
      logic [4:0]  count;
   } list_result_type;

   // Shadow of the list contents plus the queue of responses still owed by the block.
   class list_tracker;
      logic [31:0]     entries [CAPACITY];
      int unsigned     held;
      list_result_type awaited [$];
      int unsigned     failures;
      int unsigned     op_seen [8];
      int unsigned     status_seen [4];
      int unsigned     deepest;

      function logic [1:0] append_entry(logic [31:0] val);
         if (held >= CAPACITY) return ST_FULL;
         entries[held] = val;
         held++;
         return ST_OK;
      endfunction

      function void note_request(logic [2:0] op, logic [7:0] pos, logic [31:0] val);
         list_result_type r;
         logic            neg;
         int unsigned     idx;
         int unsigned     k;
         logic            in_range;
         r = '0;
         neg = pos[7];
         idx = pos;
         in_range = !neg && idx < held;
         case (op)
            OP_PUSH: r.status = append_entry(val);
            OP_POP: begin
               if (held == 0) begin
                  r.status = ST_RANGE;
               end else begin
                  held--;
                  r.item = entries[held];
                  r.has = 1'b1;
               end
            end
            OP_GET: begin
               if (!in_range) begin
                  r.status = ST_RANGE;
               end else begin
                  r.item = entries[idx];
                  r.has = 1'b1;
               end
            end
            OP_SET: begin
               if (neg) begin
                  r.status = ST_RANGE;
               end else if (!in_range) begin
                  r.status = append_entry(val);
               end else begin
                  r.item = entries[idx];
                  r.has = 1'b1;
                  entries[idx] = val;
               end
            end
            OP_INSERT: begin
               if (neg) begin
                  r.status = ST_RANGE;
               end else if (!in_range) begin
                  r.status = append_entry(val);
               end else if (held >= CAPACITY) begin
                  r.status = ST_FULL;
               end else begin
                  for (k = held; k > idx; k--) entries[k] = entries[k - 1];
                  entries[idx] = val;
                  held++;
               end
            end
            OP_REMOVE: begin
               if (!in_range) begin
                  r.status = ST_RANGE;
               end else begin
                  r.item = entries[idx];
                  r.has = 1'b1;
                  for (k = idx; k + 1 < held; k++) entries[k] = entries[k + 1];
                  held--;
               end
            end
            OP_CLEAR: held = 0;
            default: ;
         endcase
         r.count = 5'(held);
         op_seen[op]++;
         status_seen[r.status]++;
         if (held > deepest) deepest = held;
         awaited.push_back(r);
      endfunction

      function void check_result(list_result_type got);
         list_result_type want;
         if (awaited.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("Unexpected response: item %h has %0b status %0d count %0d",
                        got.item, got.has, got.status, got.count);
            return;
         end
         want = awaited.pop_front();
         if (got.item !== want.item || got.has !== want.has ||
             got.status !== want.status || got.count !== want.count) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display({"Mismatch: expected item %h has %0b status %0d count %0d,",
                         " got item %h has %0b status %0d count %0d"},
                        want.item, want.has, want.status, want.count,
                        got.item, got.has, got.status, got.count);
         end
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [2:0]  req_operation = '0;
   logic [7:0]  req_position = '0;
   logic [31:0] req_item_value = '0;
   wire         busy;
   wire         rsp_valid;
   wire  [31:0] rsp_item_out;
   wire         rsp_has_item;
   wire  [1:0]  rsp_status;
   wire  [4:0]  rsp_entry_count;

   list_tracker tracker = new;
   int          idle_pct = 0;
   int unsigned cycle_count = 0;
   bit          growing = 1'b1;

   indexed_list_store u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_item_out    (rsp_item_out),
      .rsp_has_item    (rsp_has_item),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         tracker.check_result({rsp_item_out, rsp_has_item, rsp_status, rsp_entry_count});
   end

   // Idle cycles carry junk on the request ports to show it is ignored without start.
   task automatic issue(input logic [2:0] op, input logic [7:0] pos, input logic [31:0] val);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_operation <= 3'($urandom);
         req_position <= 8'($urandom);
         req_item_value <= $urandom;
         @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_position <= pos;
      req_item_value <= val;
      do @(posedge clock); while (busy);
      tracker.note_request(op, pos, val);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // The list walks between empty and full so that shifts, full refusals and range
   // errors all come up; most positions land inside the list or just past its tail.
   task automatic random_request();
      logic [2:0]  op;
      logic [7:0]  pos;
      int unsigned roll;
      int unsigned fill;
      fill = tracker.held;
      if (fill == 0 && $urandom_range(99) < 30) growing = 1'b1;
      else if (fill == CAPACITY && $urandom_range(99) < 20) growing = 1'b0;
      else if ($urandom_range(99) < 2) growing = !growing;
      roll = $urandom_range(99);
      if (roll < 1) begin
         op = OP_CLEAR;
      end else if (roll < 2) begin
         op = OP_UNUSED;
      end else begin
         roll = $urandom_range(99);
         if (growing) begin
            if (roll < 30) op = OP_PUSH;
            else if (roll < 50) op = OP_INSERT;
            else if (roll < 65) op = OP_SET;
            else if (roll < 80) op = OP_GET;
            else if (roll < 90) op = OP_POP;
            else op = OP_REMOVE;
         end else begin
            if (roll < 25) op = OP_POP;
            else if (roll < 50) op = OP_REMOVE;
            else if (roll < 65) op = OP_GET;
            else if (roll < 80) op = OP_SET;
            else if (roll < 90) op = OP_PUSH;
            else op = OP_INSERT;
         end
      end
      roll = $urandom_range(99);
      if (roll < 75) pos = 8'($urandom_range(fill));
      else if (roll < 85) pos = 8'($urandom_range(127, fill));
      else if (roll < 93) pos = 8'($urandom_range(255, 128));
      else pos = 8'($urandom);
      issue(op, pos, $urandom);
   endtask

   initial begin
      int unsigned n;
      int          phase;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 23;

      // Corner cases on an empty list.
      issue(OP_POP, 8'd0, 32'hDEAD_BEEF);
      issue(OP_GET, 8'h80, 32'h0);
      issue(OP_REMOVE, 8'd0, 32'h0);
      issue(OP_SET, 8'd0, 32'h0000_0000);
      issue(OP_INSERT, 8'd127, 32'hFFFF_FFFF);
      for (n = 2; n < CAPACITY; n++) issue(OP_PUSH, 8'($urandom), $urandom);
      // The list is full now.
      issue(OP_PUSH, 8'd0, 32'h1234_5678);
      issue(OP_INSERT, 8'd0, 32'hAAAA_5555);
      issue(OP_SET, 8'd127, 32'h5555_AAAA);
      issue(OP_SET, 8'd0, 32'hFFFF_FFFF);
      issue(OP_GET, 8'd15, 32'h0);
      issue(OP_SET, 8'hFF, 32'h0);
      issue(OP_INSERT, 8'h80, 32'h0);
      issue(OP_REMOVE, 8'd0, 32'h0);
      issue(OP_INSERT, 8'd3, 32'h8000_0001);
      issue(OP_REMOVE, 8'd16, 32'h0);
      issue(OP_POP, 8'd0, 32'h0);
      issue(OP_UNUSED, 8'd5, 32'hCAFE_F00D);
      issue(OP_CLEAR, 8'd0, 32'h0);
      issue(OP_GET, 8'd0, 32'h0);

      for (phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 23 : (phase == 1) ? 52 : 0;
         for (n = 0; n < RANDOM_REQUESTS / 3; n++) begin
            if (phase == 1 && n == RANDOM_REQUESTS / 6) wait_drained();
            random_request();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display({"Requests: push %0d, pop %0d, get %0d, set %0d, insert %0d,",
                " remove %0d, clear %0d, unused code %0d"},
               tracker.op_seen[OP_PUSH], tracker.op_seen[OP_POP], tracker.op_seen[OP_GET],
               tracker.op_seen[OP_SET], tracker.op_seen[OP_INSERT],
               tracker.op_seen[OP_REMOVE], tracker.op_seen[OP_CLEAR],
               tracker.op_seen[OP_UNUSED]);
      $display("Statuses: ok %0d, range %0d, full %0d; deepest list %0d entries; %0d failures",
               tracker.status_seen[ST_OK], tracker.status_seen[ST_RANGE],
               tracker.status_seen[ST_FULL], tracker.deepest, tracker.failures);
      if (tracker.failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/ils_pkg.sv
hw/rtl/ils_cell.sv
hw/rtl/ils_ctrl.sv
hw/rtl/indexed_list_store.sv
tb/tb_top.sv
